/* rtl/core/mvsm_pkg.sv */
// Shared types and codes for the multi-voice sample mixer.
package mvsm_pkg;

  typedef enum logic [1:0] {
    OP_WRITE  = 2'd0,
    OP_DEFINE = 2'd1,
    OP_START  = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_LIST_FULL   = 2'd1,
    STATUS_EMPTY_SOUND = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_DEFINE,
    ST_SND_RD,
    ST_START,
    ST_TICK,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_in;
    logic mem_wr;
    logic snd_wr;
    logic start_voice;
    logic step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic list_empty;
    logic last_voice;
    logic out_busy;
  } sts_t;

endpackage

/* rtl/core/mvsm_ram.sv */
// Generic single-port-write, registered-read RAM.
module mvsm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/mvsm_ctrl.sv */
// Controller state machine that sequences each item through the datapath.
module mvsm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       in_op,
  output logic             in_ready,
  input  mvsm_pkg::sts_t   sts,
  output mvsm_pkg::cmd_t   cmd
);

  mvsm_pkg::state_t state;
  mvsm_pkg::state_t state_next;
  logic             accept;

  assign in_ready = (state == mvsm_pkg::ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mvsm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.load_in = accept;
    case (state)
      mvsm_pkg::ST_IDLE: begin
        if (accept) begin
          case (mvsm_pkg::op_t'(in_op))
            mvsm_pkg::OP_WRITE:  state_next = mvsm_pkg::ST_WRITE;
            mvsm_pkg::OP_DEFINE: state_next = mvsm_pkg::ST_DEFINE;
            mvsm_pkg::OP_START:  state_next = mvsm_pkg::ST_SND_RD;
            mvsm_pkg::OP_TICK: begin
              state_next = sts.list_empty ? mvsm_pkg::ST_FINISH : mvsm_pkg::ST_TICK;
            end
            default: state_next = mvsm_pkg::ST_FINISH;
          endcase
        end
      end
      mvsm_pkg::ST_WRITE: begin
        cmd.mem_wr = 1'b1;
        state_next = mvsm_pkg::ST_FINISH;
      end
      mvsm_pkg::ST_DEFINE: begin
        cmd.snd_wr = 1'b1;
        state_next = mvsm_pkg::ST_FINISH;
      end
      mvsm_pkg::ST_SND_RD: begin
        state_next = mvsm_pkg::ST_START;
      end
      mvsm_pkg::ST_START: begin
        cmd.start_voice = 1'b1;
        state_next      = mvsm_pkg::ST_FINISH;
      end
      mvsm_pkg::ST_TICK: begin
        cmd.step = 1'b1;
        if (sts.last_voice) begin
          state_next = mvsm_pkg::ST_DRAIN;
        end
      end
      mvsm_pkg::ST_DRAIN: begin
        state_next = mvsm_pkg::ST_FINISH;
      end
      mvsm_pkg::ST_FINISH: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = mvsm_pkg::ST_IDLE;
        end
      end
      default: state_next = mvsm_pkg::ST_IDLE;
    endcase
  end

endmodule

/* rtl/core/mvsm_datapath.sv */
// Datapath: sample and sound memories, rotating voice list, mixer and output word.
module mvsm_datapath #(
  parameter int SAMPLE_ADDR_BITS = 16,
  parameter int MAX_SOUNDS       = 16,
  parameter int MAX_VOICES       = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  mvsm_pkg::cmd_t     cmd,
  output mvsm_pkg::sts_t     sts,
  input  logic [15:0]        address,
  input  logic signed [15:0] sample_value,
  input  logic [3:0]         sound_id,
  input  logic [16:0]        sound_length,
  input  logic               repeat_req,
  output logic signed [15:0] mix_sample,
  output logic [1:0]         status,
  output logic [3:0]         active_voices,
  output logic               out_valid,
  input  logic               out_ready
);

  localparam int SUM_W  = (SAMPLE_ADDR_BITS > 18) ? SAMPLE_ADDR_BITS : 18;
  localparam int SND_AW = (MAX_SOUNDS > 1) ? $clog2(MAX_SOUNDS) : 1;
  localparam int IDX_W  = (SND_AW > 4) ? SND_AW : 4;
  localparam int CNT_W  = $clog2(MAX_VOICES + 1);
  localparam int VI_W   = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;

  // Captured input word.
  logic [15:0]        addr_r;
  logic signed [15:0] value_r;
  logic [3:0]         id_r;
  logic [16:0]        len_r;
  logic               rep_r;

  // Voice list, slot 0 is the head.
  logic [15:0] v_start [MAX_VOICES];
  logic [16:0] v_pos   [MAX_VOICES];
  logic [16:0] v_len   [MAX_VOICES];
  logic        v_loop  [MAX_VOICES];
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rem;

  logic [MAX_SOUNDS-1:0] snd_valid;
  logic [32:0]           snd_rd;
  logic [IDX_W-1:0]      id_ext;
  logic [SND_AW-1:0]     snd_idx;
  logic                  id_ok;
  logic [16:0]           slen;

  logic [SUM_W-1:0]            head_sum;
  logic [SUM_W-1:0]            wr_ext;
  logic [SAMPLE_ADDR_BITS-1:0] rd_addr;
  logic [SAMPLE_ADDR_BITS-1:0] wr_addr;
  logic [15:0]                 rd_data;

  logic [16:0] pos_inc;
  logic        done;
  logic        keep;
  logic [16:0] pos_new;
  logic        step_d;
  logic        full;

  logic signed [15:0] acc;
  logic signed [17:0] sum2;
  logic signed [16:0] half;
  logic signed [16:0] trunc;
  logic signed [15:0] acc_next;
  logic [1:0]         code;

  assign id_ext  = IDX_W'(id_r);
  assign snd_idx = id_ext[SND_AW-1:0];
  assign id_ok   = ((IDX_W + 1)'(id_r) < (IDX_W + 1)'(MAX_SOUNDS));
  assign slen    = (id_ok && snd_valid[snd_idx]) ? snd_rd[32:16] : 17'd0;
  assign full    = (count == CNT_W'(MAX_VOICES));

  assign head_sum = SUM_W'(v_start[0]) + SUM_W'(v_pos[0]);
  assign rd_addr  = head_sum[SAMPLE_ADDR_BITS-1:0];
  assign wr_ext   = SUM_W'(addr_r);
  assign wr_addr  = wr_ext[SAMPLE_ADDR_BITS-1:0];

  mvsm_ram #(
    .WIDTH(16),
    .DEPTH(1 << SAMPLE_ADDR_BITS)
  ) u_sample_ram (
    .clk    (clk),
    .wr_en  (cmd.mem_wr),
    .wr_addr(wr_addr),
    .wr_data(value_r),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  mvsm_ram #(
    .WIDTH(33),
    .DEPTH(MAX_SOUNDS)
  ) u_sound_ram (
    .clk    (clk),
    .wr_en  (cmd.snd_wr && id_ok),
    .wr_addr(snd_idx),
    .wr_data({len_r, addr_r}),
    .rd_addr(snd_idx),
    .rd_data(snd_rd)
  );

  assign pos_inc = v_pos[0] + 17'd1;
  assign done    = (pos_inc >= v_len[0]);
  assign keep    = !done || v_loop[0];
  assign pos_new = done ? 17'd0 : pos_inc;

  // Adding half a sample: (2a + s) / 2 truncated toward zero, then saturated.
  always_comb begin
    sum2  = {acc[15], acc, 1'b0} + {{2{rd_data[15]}}, rd_data};
    half  = sum2[17:1];
    trunc = half + 17'(sum2[17] & sum2[0]);
    if (trunc[16] != trunc[15]) begin
      acc_next = trunc[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      acc_next = trunc[15:0];
    end
  end

  assign sts.list_empty = (count == '0);
  assign sts.last_voice = (rem == CNT_W'(1));
  assign sts.out_busy   = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      addr_r  <= address;
      value_r <= sample_value;
      id_r    <= sound_id;
      len_r   <= sound_length;
      rep_r   <= repeat_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snd_valid <= '0;
    end else if (cmd.snd_wr && id_ok) begin
      snd_valid[snd_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      rem    <= '0;
      step_d <= 1'b0;
      acc    <= '0;
      code   <= mvsm_pkg::STATUS_OK;
    end else begin
      step_d <= cmd.step;
      if (cmd.load_in) begin
        rem  <= count;
        acc  <= '0;
        code <= mvsm_pkg::STATUS_OK;
      end else if (step_d) begin
        acc <= acc_next;
      end
      if (cmd.start_voice) begin
        if (full) begin
          code <= mvsm_pkg::STATUS_LIST_FULL;
        end else if (slen == 17'd0) begin
          code <= mvsm_pkg::STATUS_EMPTY_SOUND;
        end else begin
          count <= count + CNT_W'(1);
        end
      end
      if (cmd.step) begin
        rem <= rem - CNT_W'(1);
        if (!keep) begin
          count <= count - CNT_W'(1);
        end
      end
    end
  end

  // The head is taken each step and, if it stays, goes back in at the tail.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_VOICES; i++) begin
        v_start[i] <= '0;
        v_pos[i]   <= '0;
        v_len[i]   <= '0;
        v_loop[i]  <= 1'b0;
      end
    end else if (cmd.step) begin
      for (int i = 0; i < MAX_VOICES - 1; i++) begin
        v_start[i] <= v_start[i+1];
        v_pos[i]   <= v_pos[i+1];
        v_len[i]   <= v_len[i+1];
        v_loop[i]  <= v_loop[i+1];
      end
      if (keep) begin
        v_start[VI_W'(count - CNT_W'(1))] <= v_start[0];
        v_pos[VI_W'(count - CNT_W'(1))]   <= pos_new;
        v_len[VI_W'(count - CNT_W'(1))]   <= v_len[0];
        v_loop[VI_W'(count - CNT_W'(1))]  <= v_loop[0];
      end
    end else if (cmd.start_voice && !full && (slen != 17'd0)) begin
      v_start[VI_W'(count)] <= snd_rd[15:0];
      v_pos[VI_W'(count)]   <= '0;
      v_len[VI_W'(count)]   <= slen;
      v_loop[VI_W'(count)]  <= rep_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      mix_sample    <= acc;
      status        <= code;
      active_voices <= 4'(count);
    end
  end

endmodule

/* rtl/core/multi_voice_sample_mixer.sv */
// Top level of the multi-voice sample mixer.
// Each input word is one of four operations, selected by s_tuser: write a sample word, define a
// sound, start a voice, or tick; every word yields exactly one output word. A voice start spends
// an extra state on the sound table's registered read. A tick walks the voice list one voice per
// cycle through the single read port of the sample memory, then passes a drain state for the last
// read to land in the mixer; a tick with no active voices goes straight to the finish state. The
// block takes one word at a time and accepts the next one while a finished result still waits on
// the output. The sample memory is not cleared after reset; sound table entries read as empty
// until defined, and no start-up pass is needed.
module multi_voice_sample_mixer #(
  parameter int SAMPLE_ADDR_BITS = 16,
  parameter int MAX_SOUNDS       = 16,
  parameter int MAX_VOICES       = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // address[15:0], sample_value[31:16], sound_id[35:32], sound_length[52:36], repeat_req[53]
  input  logic [55:0] s_tdata,
  // operation[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // mix_sample[15:0], status[17:16], active_voices[21:18]
  output logic [23:0] m_tdata
);

  mvsm_pkg::cmd_t     cmd;
  mvsm_pkg::sts_t     sts;
  logic signed [15:0] mix_sample;
  logic [1:0]         status;
  logic [3:0]         active_voices;

  mvsm_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_op   (s_tuser),
    .in_ready(s_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  mvsm_datapath #(
    .SAMPLE_ADDR_BITS(SAMPLE_ADDR_BITS),
    .MAX_SOUNDS      (MAX_SOUNDS),
    .MAX_VOICES      (MAX_VOICES)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .address      (s_tdata[15:0]),
    .sample_value (s_tdata[31:16]),
    .sound_id     (s_tdata[35:32]),
    .sound_length (s_tdata[52:36]),
    .repeat_req   (s_tdata[53]),
    .mix_sample   (mix_sample),
    .status       (status),
    .active_voices(active_voices),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready)
  );

  assign m_tdata = {2'b00, active_voices, status, mix_sample};

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps
// Testbench for the multi-voice sample mixer: random and directed words, checked against a predictor.
module testbench;

  localparam int VOICE_SLOTS = 8;
  localparam int SOUND_SLOTS = 16;
  localparam int PLAN = 0;
  localparam int SEEN = 1;
  localparam int RANDOM_WORDS = 900;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    mvsm_pkg::op_t      op;
    logic [15:0]        addr;
    logic signed [15:0] value;
    logic [3:0]         sound;
    logic [16:0]        length;
    logic               looped;
  } mix_word_t;

  typedef struct packed {
    logic signed [15:0] mix;
    mvsm_pkg::status_t  status;
    logic [3:0]         voices;
  } mix_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  bit signed [15:0] smem [2][65536];
  bit [15:0]        snd_start [2][SOUND_SLOTS];
  bit [16:0]        snd_len [2][SOUND_SLOTS];
  bit [15:0]        v_start [2][VOICE_SLOTS];
  bit [16:0]        v_pos [2][VOICE_SLOTS];
  bit [16:0]        v_len [2][VOICE_SLOTS];
  bit               v_loop [2][VOICE_SLOTS];
  int               v_count [2];
  bit               written [65536];

  mix_word_t   pending_words[$];
  mix_result_t expected_out[$];
  mix_word_t   in_flight;

  int  failures = 0;
  int  cycles = 0;
  int  words_in = 0;
  int  words_out = 0;
  int  n_ticks = 0;
  int  n_clipped = 0;
  int  n_full = 0;
  int  n_empty = 0;
  int  send_gap = 0;
  int  rcv_hold = 0;
  bit  calm = 1'b0;

  multi_voice_sample_mixer DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic mix_result_t mix_step(int c, mix_word_t w);
    mix_result_t r;
    int acc;
    int t;
    int k;
    int j;
    bit [15:0] a;
    r.mix = '0;
    r.status = mvsm_pkg::STATUS_OK;
    acc = 0;
    case (w.op)
      mvsm_pkg::OP_WRITE: smem[c][w.addr] = w.value;
      mvsm_pkg::OP_DEFINE: begin
        snd_start[c][w.sound] = w.addr;
        snd_len[c][w.sound] = w.length;
      end
      mvsm_pkg::OP_START: begin
        if (v_count[c] >= VOICE_SLOTS) begin
          r.status = mvsm_pkg::STATUS_LIST_FULL;
        end else if (snd_len[c][w.sound] == 0) begin
          r.status = mvsm_pkg::STATUS_EMPTY_SOUND;
        end else begin
          v_start[c][v_count[c]] = snd_start[c][w.sound];
          v_pos[c][v_count[c]] = '0;
          v_len[c][v_count[c]] = snd_len[c][w.sound];
          v_loop[c][v_count[c]] = w.looped;
          v_count[c]++;
        end
      end
      default: begin
        k = 0;
        while (k < v_count[c]) begin
          a = v_start[c][k] + v_pos[c][k][15:0];
          t = (2 * acc + int'(smem[c][a])) / 2;
          if (t > 32767) t = 32767;
          if (t < -32768) t = -32768;
          acc = t;
          v_pos[c][k] = v_pos[c][k] + 17'd1;
          if (v_pos[c][k] >= v_len[c][k]) begin
            if (v_loop[c][k]) begin
              v_pos[c][k] = '0;
              k++;
            end else begin
              for (j = k; j + 1 < v_count[c]; j++) begin
                v_start[c][j] = v_start[c][j + 1];
                v_pos[c][j] = v_pos[c][j + 1];
                v_len[c][j] = v_len[c][j + 1];
                v_loop[c][j] = v_loop[c][j + 1];
              end
              v_count[c]--;
            end
          end else begin
            k++;
          end
        end
      end
    endcase
    r.mix = acc[15:0];
    r.voices = v_count[c][3:0];
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic mix_word_t rand_word();
    mix_word_t w;
    w.op = mvsm_pkg::op_t'($urandom_range(0, 3));
    w.addr = 16'($urandom);
    w.value = 16'($urandom);
    w.sound = 4'($urandom);
    w.length = 17'($urandom);
    w.looped = 1'($urandom);
    return w;
  endfunction

  function automatic mix_word_t make_word(mvsm_pkg::op_t op, int addr, int value, int sound,
                                          int length, bit looped);
    mix_word_t w;
    w = rand_word();
    w.op = op;
    if (op == mvsm_pkg::OP_WRITE || op == mvsm_pkg::OP_DEFINE) w.addr = addr[15:0];
    if (op == mvsm_pkg::OP_WRITE) w.value = value[15:0];
    if (op == mvsm_pkg::OP_DEFINE || op == mvsm_pkg::OP_START) w.sound = sound[3:0];
    if (op == mvsm_pkg::OP_DEFINE) w.length = length[16:0];
    if (op == mvsm_pkg::OP_START) w.looped = looped;
    return w;
  endfunction

  function automatic bit [15:0] region_addr();
    case ($urandom_range(0, 3))
      0, 1: return 16'($urandom_range(0, 63));
      2: return 16'($urandom_range(65472, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int sticky_voices();
    int n;
    n = 0;
    for (int k = 0; k < v_count[PLAN]; k++) begin
      if (v_loop[PLAN][k] || v_len[PLAN][k] > 256) n++;
    end
    return n;
  endfunction

  // A tick must never read a word that was never written, so any such word is written first.
  task automatic queue_word(mix_word_t w);
    mix_word_t fill;
    bit [15:0] a;
    if (w.op == mvsm_pkg::OP_TICK) begin
      for (int k = 0; k < v_count[PLAN]; k++) begin
        a = v_start[PLAN][k] + v_pos[PLAN][k][15:0];
        if (!written[a]) begin
          fill = make_word(mvsm_pkg::OP_WRITE, a, $urandom, 0, 0, 1'b0);
          queue_word(fill);
        end
      end
    end
    if (w.op == mvsm_pkg::OP_WRITE) written[w.addr] = 1'b1;
    void'(mix_step(PLAN, w));
    pending_words = {pending_words, w};
  endtask

  task automatic report_mismatch(string field, int got, int want);
    $display("MISMATCH on output word %0d: %s is %0d, expected %0d", words_out, field, got,
             want);
    failures++;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    mix_result_t r;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        r = mix_step(SEEN, in_flight);
        expected_out = {expected_out, r};
        words_in++;
        if (in_flight.op == mvsm_pkg::OP_TICK) n_ticks++;
        if (in_flight.op == mvsm_pkg::OP_TICK && (r.mix == 16'sh7fff || r.mix == -16'sh8000))
          n_clipped++;
        if (r.status == mvsm_pkg::STATUS_LIST_FULL) n_full++;
        if (r.status == mvsm_pkg::STATUS_EMPTY_SOUND) n_empty++;
        if (words_in % 128 == 0) calm = ($urandom_range(0, 3) == 0);
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_flight = pending_words.pop_front();
          s_tdata <= {2'b00, in_flight.looped, in_flight.length, in_flight.sound,
                      in_flight.value, in_flight.addr};
          s_tuser <= in_flight.op;
          s_tvalid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    mix_result_t want;
    mix_result_t got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.mix = m_tdata[15:0];
        got.status = mvsm_pkg::status_t'(m_tdata[17:16]);
        got.voices = m_tdata[21:18];
        if (expected_out.size() == 0) begin
          report_mismatch("unexpected word", int'(m_tdata), 0);
        end else begin
          want = expected_out.pop_front();
          if (got.mix !== want.mix) report_mismatch("mix_sample", got.mix, want.mix);
          if (got.status !== want.status) report_mismatch("status", got.status, want.status);
          if (got.voices !== want.voices) report_mismatch("active_voices", got.voices, want.voices);
        end
        words_out++;
      end
      if (rcv_hold > 0) rcv_hold--;
      else if ($urandom_range(0, 3) == 0) rcv_hold = pick_gap();
      m_tready <= (rcv_hold == 0);
    end
  end

  initial begin
    mix_word_t w;
    int r;

    // Empty tick, start of an undefined sound, then a wrapping loop plus a full list.
    queue_word(make_word(mvsm_pkg::OP_TICK, 0, 0, 0, 0, 1'b0));
    queue_word(make_word(mvsm_pkg::OP_START, 0, 0, 15, 0, 1'b1));
    queue_word(make_word(mvsm_pkg::OP_WRITE, 65535, 32767, 0, 0, 1'b0));
    queue_word(make_word(mvsm_pkg::OP_WRITE, 0, -32768, 0, 0, 1'b0));
    queue_word(make_word(mvsm_pkg::OP_WRITE, 1, -1, 0, 0, 1'b0));
    queue_word(make_word(mvsm_pkg::OP_WRITE, 65534, 1, 0, 0, 1'b0));
    queue_word(make_word(mvsm_pkg::OP_DEFINE, 65534, 0, 0, 3, 1'b0));
    queue_word(make_word(mvsm_pkg::OP_DEFINE, 65535, 0, 1, 1, 1'b0));
    queue_word(make_word(mvsm_pkg::OP_DEFINE, 0, 0, 15, 131071, 1'b0));
    queue_word(make_word(mvsm_pkg::OP_START, 0, 0, 0, 0, 1'b1));
    for (int i = 0; i < 7; i++) queue_word(make_word(mvsm_pkg::OP_START, 0, 0, 1, 0, 1'b0));
    queue_word(make_word(mvsm_pkg::OP_START, 0, 0, 5, 0, 1'b0));
    for (int i = 0; i < 4; i++) queue_word(make_word(mvsm_pkg::OP_TICK, 0, 0, 0, 0, 1'b0));

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      w = rand_word();
      r = $urandom_range(0, 99);
      if (r < 20) begin
        w.op = mvsm_pkg::OP_WRITE;
        if ($urandom_range(0, 9) < 7) w.addr = region_addr();
        case ($urandom_range(0, 7))
          0: w.value = 16'sh7fff;
          1: w.value = -16'sh8000;
          2: w.value = -16'sd1;
          3: w.value = 16'sd1;
          default: ;
        endcase
      end else if (r < 35) begin
        w.op = mvsm_pkg::OP_DEFINE;
        w.addr = region_addr();
        if (w.sound < 12)
          w.length = ($urandom_range(0, 15) == 0) ? 17'd0 : 17'($urandom_range(1, 12));
        else if ($urandom_range(0, 2) == 0) w.length = 17'($urandom_range(0, 40));
      end else if (r < 70) begin
        w.op = mvsm_pkg::OP_START;
        w.sound = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 11))
                                                : 4'($urandom_range(12, 15));
        w.looped = ($urandom_range(0, 4) == 0);
        if ((w.looped || snd_len[PLAN][w.sound] > 256) && sticky_voices() >= 3) begin
          w.looped = 1'b0;
          w.sound = 4'($urandom_range(0, 11));
        end
      end else begin
        w.op = mvsm_pkg::OP_TICK;
      end
      queue_word(w);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    while (pending_words.size() != 0 || s_tvalid) @(posedge clk);
    while (expected_out.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d words through the mixer, %0d of them ticks (%0d clipped at full scale).",
             words_in, n_ticks, n_clipped);
    $display("Starts refused: %0d with a full voice list, %0d for an empty sound.", n_full,
             n_empty);
    if (failures == 0 && words_out == words_in) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
